// ===== rtl/xcs_pkg.sv =====
// ============================================================================
// xcs_pkg - shared types and constants for the XMODEM-CRC sender
// Request and status codes, phases, the CRC-16 byte update and the
// command/status bundles between the controller and the datapath.
// ============================================================================
`default_nettype none

package xcs_pkg;

  localparam int unsigned MaxPayloadDef = 1024;
  localparam int unsigned RxDepthDef    = 16;

  localparam logic [7:0] BSoh = 8'h01;
  localparam logic [7:0] BStx = 8'h02;
  localparam logic [7:0] BEot = 8'h04;
  localparam logic [7:0] BAck = 8'h06;
  localparam logic [7:0] BNak = 8'h15;
  localparam logic [7:0] BCan = 8'h18;
  localparam logic [7:0] BPad = 8'h1A;
  localparam logic [7:0] BC   = 8'h43;
  localparam logic [2:0] MaxRetry = 3'd5;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [10:0] PaySmall = 11'd128;
  localparam logic [10:0] PayBig   = 11'd1024;

  typedef enum logic [2:0] {
    REQ_START  = 3'd0,
    REQ_RX     = 3'd1,
    REQ_CANCEL = 3'd2,
    REQ_TICK   = 3'd3,
    REQ_LOAD   = 3'd4,
    REQ_LINK   = 3'd5
  } xcs_req_e;

  typedef enum logic [2:0] {
    ST_NONE   = 3'd0,
    ST_DONE   = 3'd1,
    ST_RETRY  = 3'd2,
    ST_LOCAL  = 3'd3,
    ST_REMOTE = 3'd4,
    ST_LINK   = 3'd5
  } xcs_status_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT_C,
    PH_PREPARE,
    PH_LOAD,
    PH_SEND,
    PH_WAIT_ACK,
    PH_SEND_EOT,
    PH_WAIT_EOT_ACK
  } xcs_phase_e;

  typedef enum logic [2:0] {
    C_IDLE,
    C_FETCH,
    C_EXEC,
    C_DIV,
    C_DIVW,
    C_FIN
  } xcs_ctl_e;

  typedef enum logic [0:0] {
    CFG_MODE = 1'b0,
    CFG_LEN  = 1'b1
  } xcs_cfg_e;

  typedef struct packed {
    logic accept;    // latch the input transaction
    logic fetch;     // read payload store and receive queue
    logic exec;      // commit one protocol step
    logic div_start; // start the progress division
    logic load_out;  // move the result into the output register
  } xcs_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } xcs_sts_t;

  function automatic logic [15:0] xcs_crc8(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    c = crc ^ {d, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/xmodem_crc_sender_top.sv =====
// ============================================================================
// xmodem_crc_sender_top - XMODEM-CRC / 1K sender
// Frames file bytes into SOH/STX packets with CRC-16, handles ACK/NAK/CAN,
// EOT, retry limit, link loss and progress reporting.
// ============================================================================
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  in       | in_valid_i/in_stall_o| req_type_i rx_byte_i load_byte_i link_up_i
//  out      | out_valid_o/out_stall_i | tx_valid_o tx_byte_o data_request_o
//           |                      | request_offset_o request_count_o
//           |                      | status_code_o progress_percent_o busy_res_o
//  cfg      | cfg_valid_i/cfg_ready_o | cfg_index_i cfg_data_i
//
// A transaction passes accept, memory fetch (payload store and receive
// queue, registered read), execute and result load. The last byte of a
// first-time frame with a nonzero file length, and the first transaction
// after a file_length write, also run the progress divider (multiply,
// range check, then 7 restoring steps unless the range check clamps).
// One transaction is in flight at a time; the next is accepted while the
// previous result still sits in the output register.
// Reset is asynchronous, active low; payload store and queue are not cleared.
// out_stall_i holds the output register and its load; config is always ready.
//
`default_nettype none

module xmodem_crc_sender_top #(
  parameter int unsigned MaxPayload = xcs_pkg::MaxPayloadDef,
  parameter int unsigned RxDepth    = xcs_pkg::RxDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [7:0]  load_byte_i,
  input  wire logic        link_up_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             tx_valid_o,
  output logic [7:0]       tx_byte_o,
  output logic             data_request_o,
  output logic [23:0]      request_offset_o,
  output logic [10:0]      request_count_o,
  output logic [2:0]       status_code_o,
  output logic [6:0]       progress_percent_o,
  output logic             busy_res_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);
  import xcs_pkg::*;

  xcs_cmd_t    cmd;
  xcs_sts_t    sts;
  logic        div_done;
  logic [6:0]  div_pct;
  logic [23:0] sent, len;

  assign cfg_ready_o = 1'b1;

  // sequencer: one transaction at a time
  xcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // progress: sent*100/len, recomputed when bytes_sent or file_length moves
  xcs_pct u_pct (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd.div_start),
    .sent_i  (sent),
    .len_i   (len),
    .done_o  (div_done),
    .pct_o   (div_pct)
  );

  xcs_dp #(
    .MaxPayload (MaxPayload),
    .RxDepth    (RxDepth)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .req_type_i         (req_type_i),
    .rx_byte_i          (rx_byte_i),
    .load_byte_i        (load_byte_i),
    .link_up_i          (link_up_i),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .div_done_i         (div_done),
    .div_pct_i          (div_pct),
    .sent_o             (sent),
    .len_o              (len),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .tx_valid_o         (tx_valid_o),
    .tx_byte_o          (tx_byte_o),
    .data_request_o     (data_request_o),
    .request_offset_o   (request_offset_o),
    .request_count_o    (request_count_o),
    .status_code_o      (status_code_o),
    .progress_percent_o (progress_percent_o),
    .busy_res_o         (busy_res_o)
  );

endmodule

`default_nettype wire

// ===== rtl/xcs_pct.sv =====
// ============================================================================
// xcs_pct - progress percent divider
// sent*100/len clamped to 100: a multiply step, a range check that may clamp
// at once, else seven restoring steps, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module xcs_pct (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [23:0] sent_i,
  input  wire logic [23:0] len_i,
  output logic             done_o,
  output logic [6:0]       pct_o
);
  import xcs_pkg::*;

  logic [30:0] prod_q, rem_q, dvs_q;
  logic [6:0]  quo_q;
  logic [2:0]  cnt_q;
  logic        mul_q, run_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        mul_q <= 1'b1;
      end else if (mul_q) begin
        mul_q <= 1'b0;
        if (prod_q >= {len_i, 7'b0}) begin
          done_q <= 1'b1;
        end else begin
          run_q <= 1'b1;
          cnt_q <= 3'd6;
        end
      end else if (run_q) begin
        cnt_q <= cnt_q - 3'd1;
        if (cnt_q == 3'd0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= 31'(sent_i) * 31'd100;
    end else if (mul_q) begin
      rem_q <= prod_q;
      dvs_q <= {1'b0, len_i, 6'b0};
      quo_q <= (prod_q >= {len_i, 7'b0}) ? 7'd100 : 7'd0;
    end else if (run_q) begin
      if (rem_q >= dvs_q) begin
        rem_q <= rem_q - dvs_q;
        quo_q <= {quo_q[5:0], 1'b1};
      end else begin
        quo_q <= {quo_q[5:0], 1'b0};
      end
      dvs_q <= dvs_q >> 1;
    end
  end

  assign done_o = done_q;
  assign pct_o  = (quo_q > 7'd100) ? 7'd100 : quo_q;

endmodule

`default_nettype wire

// ===== rtl/xcs_ctrl.sv =====
// ============================================================================
// xcs_ctrl - transaction sequencer
// Walks each accepted transaction through fetch, execute, optional
// division and result hand-off.
// ============================================================================
`default_nettype none

module xcs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire xcs_pkg::xcs_sts_t sts_i,
  output xcs_pkg::xcs_cmd_t      cmd_o
);
  import xcs_pkg::*;

  xcs_ctl_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      C_IDLE:  if (in_valid_i) state_d = C_FETCH;
      C_FETCH: state_d = C_EXEC;
      C_EXEC:  state_d = sts_i.need_div ? C_DIV : C_FIN;
      C_DIV:   state_d = C_DIVW;
      C_DIVW:  if (sts_i.div_done) state_d = C_FIN;
      C_FIN:   if (sts_i.out_free) state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      C_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      C_FETCH: cmd_o.fetch = 1'b1;
      C_EXEC:  cmd_o.exec = 1'b1;
      C_DIV:   cmd_o.div_start = 1'b1;
      C_FIN:   cmd_o.load_out = sts_i.out_free;
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> $past(cmd_o.fetch))
    else $error("exec without fetch");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> !cmd_o.accept && in_stall_o)
    else $error("second transaction taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> $past(cmd_o.exec) && $past(sts_i.need_div))
    else $error("division started without request");

endmodule

`default_nettype wire

// ===== rtl/xcs_dp.sv =====
// ============================================================================
// xcs_dp - sender datapath
// Protocol state, payload store, receive queue, frame builder with CRC,
// and the output register.
// ============================================================================
`default_nettype none

module xcs_dp #(
  parameter int unsigned MaxPayload = xcs_pkg::MaxPayloadDef,
  parameter int unsigned RxDepth    = xcs_pkg::RxDepthDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire xcs_pkg::xcs_cmd_t cmd_i,
  output xcs_pkg::xcs_sts_t      sts_o,
  input  wire logic [2:0]        req_type_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic [7:0]        load_byte_i,
  input  wire logic              link_up_i,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [23:0]       cfg_data_i,
  input  wire logic              div_done_i,
  input  wire logic [6:0]        div_pct_i,
  output logic [23:0]            sent_o,
  output logic [23:0]            len_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   tx_valid_o,
  output logic [7:0]             tx_byte_o,
  output logic                   data_request_o,
  output logic [23:0]            request_offset_o,
  output logic [10:0]            request_count_o,
  output logic [2:0]             status_code_o,
  output logic [6:0]             progress_percent_o,
  output logic                   busy_res_o
);
  import xcs_pkg::*;

  localparam int unsigned Aw   = $clog2(MaxPayload);
  localparam int unsigned RxAw = (RxDepth > 1) ? $clog2(RxDepth) : 1;
  localparam int unsigned Fw   = $clog2(RxDepth + 1);
  localparam bit          BigOk = (MaxPayload >= 1024);

  // latched transaction
  logic [2:0] req_q;
  logic [7:0] rxb_q, ldb_q;
  logic       lnk_q;

  // configuration
  logic        mode_q;
  logic [23:0] flen_q;

  // protocol state
  xcs_phase_e  phase_q, phase_d;
  logic [7:0]  pnum_q, pnum_d;
  logic [23:0] poff_q, poff_d, sent_q, sent_d;
  logic [2:0]  retry_q, retry_d;
  logic [10:0] pos_q, pos_d, bip_q, bip_d, loaded_q, loaded_d;
  logic [15:0] crc_q, crc_d;
  logic [Fw-1:0]   fill_q, fill_d;
  logic [RxAw-1:0] wr_q, wr_d, rd_q, rd_d;
  logic        link_q, link_d;
  logic [6:0]  pct_q;
  logic        pct_dirty_q;  // file length changed, percent must be redone

  // memories
  logic [7:0] pay_mem [MaxPayload];
  logic [7:0] rxq_mem [RxDepth];
  logic [7:0] pay_rd_q, rxq_rd_q;

  // step results
  logic        push, pop, pay_we, fin, clr, need_div;
  xcs_status_e fin_code;
  logic        r_txv, r_dreq;
  logic [7:0]  r_txb;
  logic [23:0] r_off, r_rem;
  logic [10:0] r_cnt, psz, pay_idx;
  logic [7:0]  snd_b;
  logic        busy_q;

  // staged result
  logic        s_txv_q, s_dreq_q, s_busy_q;
  logic [7:0]  s_txb_q;
  logic [23:0] s_off_q;
  logic [10:0] s_cnt_q;
  logic [2:0]  s_st_q;
  logic        out_valid_q;

  assign busy_q  = (phase_q != PH_IDLE);
  assign psz     = (mode_q && BigOk) ? PayBig : PaySmall;
  assign pay_idx = pos_q - 11'd3;

  function automatic logic [RxAw-1:0] rx_inc(input logic [RxAw-1:0] p);
    return (p == RxAw'(RxDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= req_type_i;
      rxb_q <= rx_byte_i;
      ldb_q <= load_byte_i;
      lnk_q <= link_up_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pay_we && cmd_i.exec) pay_mem[loaded_q[Aw-1:0]] <= ldb_q;
    if (cmd_i.fetch) pay_rd_q <= pay_mem[pay_idx[Aw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (push && cmd_i.exec) rxq_mem[wr_q] <= rxb_q;
    if (cmd_i.fetch) rxq_rd_q <= rxq_mem[rd_q];
  end

  // frame byte for the data part of a frame
  always_comb begin
    if (pay_idx < bip_q && pay_idx < 11'(MaxPayload)) begin
      snd_b = pay_rd_q;
    end else begin
      snd_b = BPad;
    end
  end

  always_comb begin
    phase_d  = phase_q;  pnum_d   = pnum_q;   poff_d = poff_q;
    sent_d   = sent_q;   retry_d  = retry_q;  pos_d  = pos_q;
    bip_d    = bip_q;    loaded_d = loaded_q; crc_d  = crc_q;
    fill_d   = fill_q;   wr_d     = wr_q;     rd_d   = rd_q;
    link_d   = link_q;
    push = 1'b0; pop = 1'b0; pay_we = 1'b0; fin = 1'b0; clr = 1'b0;
    need_div = 1'b0; fin_code = ST_NONE;
    r_txv = 1'b0; r_txb = '0; r_dreq = 1'b0; r_off = '0; r_cnt = '0;
    r_rem = flen_q - poff_q;
    case (req_q)
      REQ_START: begin
        if (!busy_q) begin
          phase_d = PH_WAIT_C;
          pnum_d = '0; poff_d = '0; sent_d = '0; retry_d = '0; pos_d = '0;
          bip_d = '0; loaded_d = '0; crc_d = '0;
          clr = 1'b1;
        end
      end
      REQ_RX: begin
        if (busy_q) begin
          if (rxb_q == BCan) begin
            fin = 1'b1; fin_code = ST_REMOTE;
          end else if (fill_q < Fw'(RxDepth)) begin
            push = 1'b1;
          end
        end
      end
      REQ_CANCEL: begin
        if (busy_q) begin
          r_txv = 1'b1; r_txb = BCan;
          fin = 1'b1; fin_code = ST_LOCAL;
        end
      end
      REQ_TICK: begin
        if (busy_q && !link_q) begin
          fin = 1'b1; fin_code = ST_LINK;
        end else begin
          case (phase_q)
            PH_WAIT_C: begin
              if (fill_q != '0) begin
                pop = 1'b1;
                if (rxq_rd_q == BC) phase_d = PH_PREPARE;
              end
              retry_d = '0;
            end
            PH_PREPARE: begin
              pnum_d = pnum_q + 8'd1;
              if (poff_q < flen_q) begin
                bip_d = (r_rem > 24'(psz)) ? psz : r_rem[10:0];
              end else begin
                bip_d = '0;
              end
              loaded_d = '0;
              pos_d = '0;
              r_dreq = 1'b1; r_off = poff_q; r_cnt = bip_d;
              phase_d = (bip_d == '0) ? PH_SEND : PH_LOAD;
            end
            PH_SEND: begin
              r_txv = 1'b1;
              pos_d = pos_q + 11'd1;
              if (pos_q == 11'd0) begin
                r_txb = (psz == PayBig) ? BStx : BSoh;
                crc_d = '0;
              end else if (pos_q == 11'd1) begin
                r_txb = pnum_q;
              end else if (pos_q == 11'd2) begin
                r_txb = ~pnum_q;
              end else if (pos_q < 11'd3 + psz) begin
                r_txb = snd_b;
                crc_d = xcs_crc8(crc_q, snd_b);
              end else if (pos_q == 11'd3 + psz) begin
                r_txb = crc_q[15:8];
              end else begin
                r_txb = crc_q[7:0];
                if (retry_q == '0) begin
                  sent_d = sent_q + 24'(bip_q);
                  need_div = (flen_q != '0);
                end
                phase_d = PH_WAIT_ACK;
                pos_d = '0;
              end
            end
            PH_WAIT_ACK: begin
              if (fill_q != '0) begin
                pop = 1'b1;
                if (rxq_rd_q == BAck) begin
                  if ({1'b0, poff_q} + 25'(psz) >= {1'b0, flen_q}) begin
                    phase_d = PH_SEND_EOT;
                  end else begin
                    poff_d = poff_q + 24'(psz);
                    phase_d = PH_PREPARE;
                  end
                  retry_d = '0;
                end else if (rxq_rd_q == BNak) begin
                  retry_d = retry_q + 3'd1;
                  if (retry_d > MaxRetry) begin
                    fin = 1'b1; fin_code = ST_RETRY;
                  end else begin
                    pos_d = '0;
                    phase_d = PH_SEND;
                  end
                end
              end
            end
            PH_SEND_EOT: begin
              r_txv = 1'b1; r_txb = BEot;
              phase_d = PH_WAIT_EOT_ACK;
            end
            PH_WAIT_EOT_ACK: begin
              if (fill_q != '0) begin
                pop = 1'b1;
                if (rxq_rd_q == BAck) begin
                  fin = 1'b1; fin_code = ST_DONE;
                end
              end
            end
            default: ;
          endcase
        end
      end
      REQ_LOAD: begin
        if (phase_q == PH_LOAD && loaded_q < bip_q) begin
          pay_we = (loaded_q < 11'(MaxPayload));
          loaded_d = loaded_q + 11'd1;
          if (loaded_d >= bip_q) begin
            pos_d = '0;
            phase_d = PH_SEND;
          end
        end
      end
      REQ_LINK: link_d = lnk_q;
      default: ;
    endcase
    if (push) begin
      fill_d = fill_q + 1'b1;
      wr_d   = rx_inc(wr_q);
    end
    if (pop) begin
      fill_d = fill_q - 1'b1;
      rd_d   = rx_inc(rd_q);
    end
    if (fin || clr) begin
      fill_d = '0; wr_d = '0; rd_d = '0;
    end
    if (fin) phase_d = PH_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0; flen_q <= '0;
      phase_q <= PH_IDLE; pnum_q <= '0; poff_q <= '0; sent_q <= '0;
      retry_q <= '0; pos_q <= '0; bip_q <= '0; loaded_q <= '0; crc_q <= '0;
      fill_q <= '0; wr_q <= '0; rd_q <= '0; link_q <= 1'b0; pct_q <= '0;
      pct_dirty_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == {1'b0, CFG_MODE}) mode_q <= cfg_data_i[0];
        if (cfg_index_i == {1'b0, CFG_LEN})  flen_q <= cfg_data_i;
      end
      // a new file length redoes the percent on the next transaction
      if (cfg_we_i && cfg_index_i == {1'b0, CFG_LEN}) begin
        pct_dirty_q <= 1'b1;
      end else if (cmd_i.exec) begin
        pct_dirty_q <= 1'b0;
      end
      if (cmd_i.exec) begin
        phase_q <= phase_d; pnum_q <= pnum_d; poff_q <= poff_d; sent_q <= sent_d;
        retry_q <= retry_d; pos_q <= pos_d; bip_q <= bip_d; loaded_q <= loaded_d;
        crc_q <= crc_d; fill_q <= fill_d; wr_q <= wr_d; rd_q <= rd_d;
        link_q <= link_d;
        if (clr) pct_q <= '0;
      end else if (div_done_i) begin
        pct_q <= div_pct_i;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      s_txv_q <= r_txv; s_txb_q <= r_txb; s_dreq_q <= r_dreq;
      s_off_q <= r_off; s_cnt_q <= r_cnt; s_st_q <= fin_code;
      s_busy_q <= (phase_d != PH_IDLE);
    end
    if (cmd_i.load_out) begin
      tx_valid_o       <= s_txv_q;
      tx_byte_o        <= s_txb_q;
      data_request_o   <= s_dreq_q;
      request_offset_o <= s_off_q;
      request_count_o  <= s_cnt_q;
      status_code_o    <= s_st_q;
      busy_res_o       <= s_busy_q;
      progress_percent_o <= (s_busy_q && flen_q != '0) ? pct_q : 7'd0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.need_div = need_div || pct_dirty_q;
  assign sts_o.div_done = div_done_i;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sent_o = sent_q;
  assign len_o  = flen_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= Fw'(RxDepth))
    else $error("receive queue overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !tx_valid_o |-> tx_byte_o == 8'd0)
    else $error("stray transmit byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> fill_q == '0)
    else $error("queue not empty while idle");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// XMODEM-CRC sender testbench
// Drives protocol-aware request transactions (starts, partner bytes, ticks,
// file loads, link changes, noise), predicts each untyped result with an
// in-bench sender model and checks each result transaction field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import xcs_pkg::*;

  // one result transaction
  typedef struct packed {
    logic        txv;
    logic [7:0]  txb;
    logic        dreq;
    logic [23:0] roff;
    logic [10:0] rcnt;
    logic [2:0]  status;
    logic [6:0]  pct;
    logic        busy;
  } rsp_t;

  // one row of the directed table
  typedef struct packed {
    logic [2:0] req;
    logic [7:0] rx;
    logic [7:0] ld;
    logic       link;
    logic       typed;  // expected result typed in below, else predicted
    rsp_t       rsp;
  } row_t;

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [2:0]  req_type;
  logic [7:0]  rx_byte, load_byte;
  logic        link_up;
  logic        out_valid, out_stall;
  rsp_t        got;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  xmodem_crc_sender_top DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type), .rx_byte_i(rx_byte), .load_byte_i(load_byte),
    .link_up_i(link_up),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .tx_valid_o(got.txv), .tx_byte_o(got.txb), .data_request_o(got.dreq),
    .request_offset_o(got.roff), .request_count_o(got.rcnt),
    .status_code_o(got.status), .progress_percent_o(got.pct),
    .busy_res_o(got.busy),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #(12 * 4000000);
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender model: its own copy of the registers and the protocol state
  // --------------------------------------------------------------------------
  logic             m_mode;
  logic [23:0]      m_flen;
  xcs_phase_e       m_ph;
  logic [7:0]       m_pnum;
  logic [23:0]      m_poff, m_sent;
  logic [2:0]       m_retry;
  logic [10:0]      m_fpos, m_bip, m_loaded;
  logic [15:0]      m_crc;
  logic [7:0]       m_store [1024];
  logic [7:0]       m_rxq [$];
  logic             m_link;

  rsp_t             rsp_expect [$];   // expected results, oldest first
  int               errors, n_rsp, n_items, n_frames_done, n_retry_abort;

  function automatic logic [15:0] crc16_upd(logic [15:0] c, logic [7:0] d);
    logic [15:0] r;
    r = c ^ {d, 8'h00};
    for (int k = 0; k < 8; k++) r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
    return r;
  endfunction

  function automatic int unsigned pkt_size();
    return m_mode ? 1024 : 128;
  endfunction

  // transfer ends: back to idle, queue flushed
  task automatic end_xfer(xcs_status_e code, inout rsp_t r);
    m_ph = PH_IDLE;
    m_rxq.delete();
    r.status = code;
  endtask

  task automatic frame_byte(inout rsp_t r);
    int unsigned p, pos, idx;
    logic [7:0]  b;
    p = pkt_size();
    pos = m_fpos;
    if (pos == 0) begin
      b = (p == 1024) ? BStx : BSoh;
      m_crc = '0;
    end else if (pos == 1) b = m_pnum;
    else if (pos == 2) b = 8'hFF - m_pnum;
    else if (pos < 3 + p) begin
      idx = pos - 3;
      b = (idx < m_bip) ? m_store[idx] : BPad;
      m_crc = crc16_upd(m_crc, b);
    end else if (pos == 3 + p) b = m_crc[15:8];
    else begin
      b = m_crc[7:0];
      if (m_retry == 0) m_sent = m_sent + 24'(m_bip);
      m_ph = PH_WAIT_ACK;
      pos = 32'h7FF;  // wraps frame position to zero below
      n_frames_done++;
    end
    m_fpos = 11'(pos + 1);
    r.txv = 1'b1;
    r.txb = b;
  endtask

  task automatic tick_step(inout rsp_t r);
    logic [7:0]  b;
    int unsigned p, left;
    if (m_ph != PH_IDLE && !m_link) begin
      end_xfer(ST_LINK, r);
      return;
    end
    p = pkt_size();
    case (m_ph)
      PH_WAIT_C: begin
        if (m_rxq.size() > 0) begin
          b = m_rxq.pop_front();
          if (b == BC) m_ph = PH_PREPARE;
        end
        m_retry = '0;
      end
      PH_PREPARE: begin
        m_pnum++;
        left = (m_poff < m_flen) ? m_flen - m_poff : 0;
        if (left > p) left = p;
        m_bip = 11'(left);
        m_loaded = '0;
        m_fpos = '0;
        r.dreq = 1'b1;
        r.roff = m_poff;
        r.rcnt = m_bip;
        m_ph = (m_bip == 0) ? PH_SEND : PH_LOAD;
      end
      PH_SEND: frame_byte(r);
      PH_WAIT_ACK: begin
        if (m_rxq.size() > 0) begin
          b = m_rxq.pop_front();
          if (b == BAck) begin
            if (int'(m_poff) + p >= int'(m_flen)) m_ph = PH_SEND_EOT;
            else begin
              m_poff = m_poff + 24'(p);
              m_ph = PH_PREPARE;
            end
            m_retry = '0;
          end else if (b == BNak) begin
            m_retry++;
            if (m_retry > MaxRetry) begin
              end_xfer(ST_RETRY, r);
              n_retry_abort++;
            end else begin
              m_fpos = '0;
              m_ph = PH_SEND;
            end
          end
        end
      end
      PH_SEND_EOT: begin
        r.txv = 1'b1;
        r.txb = BEot;
        m_ph = PH_WAIT_EOT_ACK;
      end
      PH_WAIT_EOT_ACK: begin
        if (m_rxq.size() > 0) begin
          b = m_rxq.pop_front();
          if (b == BAck) end_xfer(ST_DONE, r);
        end
      end
      default: ;
    endcase
  endtask

  // predicts the result of one accepted request transaction
  task automatic sender_step(input logic [2:0] req, input logic [7:0] rx,
                             input logic [7:0] ld, input logic lk, output rsp_t r);
    longint unsigned pc;
    r = '0;
    case (req)
      REQ_START: if (m_ph == PH_IDLE) begin
        m_ph = PH_WAIT_C;
        m_pnum = '0; m_poff = '0; m_sent = '0; m_retry = '0; m_fpos = '0;
        m_bip = '0; m_loaded = '0; m_crc = '0;
        m_rxq.delete();
      end
      REQ_RX: if (m_ph != PH_IDLE) begin
        if (rx == BCan) end_xfer(ST_REMOTE, r);
        else if (m_rxq.size() < RxDepthDef) m_rxq.push_back(rx);
      end
      REQ_CANCEL: if (m_ph != PH_IDLE) begin
        r.txv = 1'b1;
        r.txb = BCan;
        end_xfer(ST_LOCAL, r);
      end
      REQ_TICK: tick_step(r);
      REQ_LOAD: if (m_ph == PH_LOAD && m_loaded < m_bip) begin
        m_store[m_loaded[9:0]] = ld;
        m_loaded++;
        if (m_loaded >= m_bip) begin
          m_fpos = '0;
          m_ph = PH_SEND;
        end
      end
      REQ_LINK: m_link = lk;
      default: ;
    endcase
    r.busy = (m_ph != PH_IDLE);
    if (r.busy && m_flen != 0) begin
      pc = (longint'(m_sent) * 100) / m_flen;
      r.pct = (pc > 100) ? 7'd100 : 7'(pc);
    end
  endtask

  task automatic report_mismatch(string field, int unsigned g, int unsigned e);
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h", n_rsp, field, g, e);
    errors++;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall, long hold-off on request, field checks
  // --------------------------------------------------------------------------
  int stall_pct;   // receiver stall chance per cycle, in percent
  int idle_pct;    // sender gap chance per cycle, in percent
  int hold_left;   // cycles of forced stall still to go

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (rsp_expect.size() == 0) begin
        $display("unexpected result transaction %0d", n_rsp);
        errors++;
      end else begin
        e = rsp_expect.pop_front();
        if (got.txv    !== e.txv)    report_mismatch("tx_valid", got.txv, e.txv);
        if (got.txb    !== e.txb)    report_mismatch("tx_byte", got.txb, e.txb);
        if (got.dreq   !== e.dreq)   report_mismatch("data_request", got.dreq, e.dreq);
        if (got.roff   !== e.roff)   report_mismatch("request_offset", got.roff, e.roff);
        if (got.rcnt   !== e.rcnt)   report_mismatch("request_count", got.rcnt, e.rcnt);
        if (got.status !== e.status) report_mismatch("status_code", got.status, e.status);
        if (got.pct    !== e.pct)    report_mismatch("progress", got.pct, e.pct);
        if (got.busy   !== e.busy)   report_mismatch("busy", got.busy, e.busy);
      end
      n_rsp++;
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // offers one request transaction, waits for acceptance and records the
  // expectation; a typed row replaces the predicted result
  task automatic offer(logic [2:0] req, logic [7:0] rx, logic [7:0] ld, logic lk,
                       logic typed, rsp_t typed_rsp);
    rsp_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    req_type = req; rx_byte = rx; load_byte = ld; link_up = lk;
    do @(posedge clk); while (in_stall);
    sender_step(req, rx, ld, lk, r);
    rsp_expect.push_back(typed ? typed_rsp : r);
    n_items++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (rsp_expect.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic cfg_write(xcs_cfg_e idx, logic [23:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = 2'(idx);
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MODE) m_mode = val[0];
    else m_flen = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // protocol-aware random request: mostly well-formed, some noise
  bit nak_heavy;
  int burst_left;

  task automatic random_request(output logic [2:0] req, output logic [7:0] rx,
                                output logic [7:0] ld, output logic lk);
    logic [7:0] reply;
    req = REQ_TICK; rx = 8'($urandom); ld = 8'($urandom); lk = 1'b1;
    if (burst_left > 0) begin
      // flood the receive queue past its depth
      burst_left--;
      req = REQ_RX;
      if (rx == BCan) rx = BAck;
    end else if ($urandom_range(99) < 6) begin
      req = 3'($urandom_range(7));
      lk = ($urandom_range(9) != 0);
      if ($urandom_range(3) == 0) burst_left = 20;
    end else if (!m_link) req = REQ_LINK;
    else if ($urandom_range(399) == 0) req = REQ_CANCEL;
    else case (m_ph)
      PH_IDLE: begin
        req = REQ_START;
        nak_heavy = ($urandom_range(3) == 0);
      end
      PH_LOAD: req = REQ_LOAD;
      PH_WAIT_C: if (m_rxq.size() == 0) begin
        req = REQ_RX;
        if ($urandom_range(7) != 0) rx = BC;
      end
      PH_WAIT_ACK, PH_WAIT_EOT_ACK: if (m_rxq.size() == 0) begin
        req = REQ_RX;
        if (nak_heavy) reply = ($urandom_range(9) < 8) ? BNak : BAck;
        else if ($urandom_range(19) < 17) reply = BAck;
        else reply = ($urandom_range(1) == 0) ? BNak : rx;
        rx = reply;
      end
      default: ;
    endcase
  endtask

  row_t dir_tab [$];

  function automatic row_t row(logic [2:0] req, logic [7:0] rx, logic [7:0] ld, logic lk,
                               logic typed, logic txv, logic [7:0] txb, logic dreq,
                               logic [2:0] st, logic busy);
    row_t w;
    w = '0;
    w.req = req; w.rx = rx; w.ld = ld; w.link = lk; w.typed = typed;
    w.rsp.txv = txv; w.rsp.txb = txb; w.rsp.dreq = dreq;
    w.rsp.status = st; w.rsp.busy = busy;
    return w;
  endfunction

  initial begin
    logic [2:0] req;
    logic [7:0] rx, ld;
    logic       lk;
    int         n_phase;
    rst_n = 1'b0;
    in_valid = 1'b0; req_type = '0; rx_byte = '0; load_byte = '0; link_up = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    stall_pct = 0; idle_pct = 0; hold_left = 0;
    errors = 0; n_rsp = 0; n_items = 0; n_frames_done = 0; n_retry_abort = 0;
    burst_left = 0; nak_heavy = 1'b0;
    m_mode = 1'b0; m_flen = '0; m_ph = PH_IDLE; m_pnum = '0; m_poff = '0;
    m_sent = '0; m_retry = '0; m_fpos = '0; m_bip = '0; m_loaded = '0;
    m_crc = '0; m_link = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, registers at reset values (128-byte mode, empty file).
    // Idle: everything but a start or a link change is ignored.
    dir_tab.push_back(row(REQ_TICK,   8'h00, 8'h00, 0, 1, 0, 8'h00, 0, ST_NONE, 0));
    dir_tab.push_back(row(REQ_CANCEL, 8'h00, 8'h00, 0, 1, 0, 8'h00, 0, ST_NONE, 0));
    dir_tab.push_back(row(REQ_RX,     8'hFF, 8'h00, 0, 1, 0, 8'h00, 0, ST_NONE, 0));
    dir_tab.push_back(row(REQ_LOAD,   8'h00, 8'hFF, 0, 1, 0, 8'h00, 0, ST_NONE, 0));
    dir_tab.push_back(row(3'd6,       8'hFF, 8'hFF, 1, 1, 0, 8'h00, 0, ST_NONE, 0));
    dir_tab.push_back(row(3'd7,       8'hFF, 8'hFF, 1, 1, 0, 8'h00, 0, ST_NONE, 0));
    dir_tab.push_back(row(REQ_LINK,   8'h00, 8'h00, 1, 1, 0, 8'h00, 0, ST_NONE, 0));
    // start, second start ignored, 'C' handshake, empty packet request
    dir_tab.push_back(row(REQ_START,  8'h00, 8'h00, 0, 1, 0, 8'h00, 0, ST_NONE, 1));
    dir_tab.push_back(row(REQ_START,  8'h00, 8'h00, 0, 1, 0, 8'h00, 0, ST_NONE, 1));
    dir_tab.push_back(row(REQ_RX,     BC,    8'h00, 0, 1, 0, 8'h00, 0, ST_NONE, 1));
    dir_tab.push_back(row(REQ_TICK,   8'h00, 8'h00, 0, 1, 0, 8'h00, 0, ST_NONE, 1));
    dir_tab.push_back(row(REQ_TICK,   8'h00, 8'h00, 0, 1, 0, 8'h00, 1, ST_NONE, 1));
    // load outside the loading phase is ignored, then header and padding
    dir_tab.push_back(row(REQ_LOAD,   8'h00, 8'h00, 0, 1, 0, 8'h00, 0, ST_NONE, 1));
    dir_tab.push_back(row(REQ_TICK,   8'h00, 8'h00, 0, 1, 1, BSoh,  0, ST_NONE, 1));
    dir_tab.push_back(row(REQ_TICK,   8'h00, 8'h00, 0, 1, 1, 8'h01, 0, ST_NONE, 1));
    dir_tab.push_back(row(REQ_TICK,   8'h00, 8'h00, 0, 1, 1, 8'hFE, 0, ST_NONE, 1));
    dir_tab.push_back(row(REQ_TICK,   8'h00, 8'h00, 0, 1, 1, BPad,  0, ST_NONE, 1));
    dir_tab.push_back(row(REQ_TICK,   8'h00, 8'h00, 0, 0, 0, 8'h00, 0, ST_NONE, 1));
    // local cancel sends CAN
    dir_tab.push_back(row(REQ_CANCEL, 8'h00, 8'h00, 0, 1, 1, BCan,  0, ST_LOCAL, 0));
    // remote cancel
    dir_tab.push_back(row(REQ_START,  8'h00, 8'h00, 0, 1, 0, 8'h00, 0, ST_NONE, 1));
    dir_tab.push_back(row(REQ_RX,     BCan,  8'h00, 0, 1, 0, 8'h00, 0, ST_REMOTE, 0));
    // link lost, seen at the next tick
    dir_tab.push_back(row(REQ_START,  8'h00, 8'h00, 0, 1, 0, 8'h00, 0, ST_NONE, 1));
    dir_tab.push_back(row(REQ_LINK,   8'h00, 8'h00, 0, 1, 0, 8'h00, 0, ST_NONE, 1));
    dir_tab.push_back(row(REQ_TICK,   8'h00, 8'h00, 0, 1, 0, 8'h00, 0, ST_LINK, 0));
    dir_tab.push_back(row(REQ_LINK,   8'h00, 8'h00, 1, 1, 0, 8'h00, 0, ST_NONE, 0));
    foreach (dir_tab[i])
      offer(dir_tab[i].req, dir_tab[i].rx, dir_tab[i].ld, dir_tab[i].link,
            dir_tab[i].typed, dir_tab[i].rsp);

    // Random phases. Registers change only once the block has drained.
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          cfg_write(CFG_MODE, 24'd0);
          cfg_write(CFG_LEN, 24'($urandom_range(1, 400)));
          idle_pct = 22; stall_pct = 87; n_phase = 150;
        end
        1: begin
          // 1K frames, short file so most of each frame is padding
          cfg_write(CFG_MODE, 24'd1);
          cfg_write(CFG_LEN, 24'($urandom_range(1, 40)));
          idle_pct = 87; stall_pct = 22; n_phase = 300;
        end
        2: begin
          cfg_write(CFG_MODE, 24'd0);
          cfg_write(CFG_LEN, 24'hFFFFFF);
          idle_pct = 0; stall_pct = 0; n_phase = 100;
        end
        default: begin
          cfg_write(CFG_LEN, 24'($urandom_range(129, 300)));
          idle_pct = 0; stall_pct = 0; n_phase = 120;
        end
      endcase
      for (int i = 0; i < n_phase; i++) begin
        // receiver holds off for a long stretch while requests keep coming
        if (ph == 0 && i == 100) hold_left = 300;
        // sender pauses until every outstanding result is back
        if (ph == 1 && i == 50) wait_drained();
        random_request(req, rx, ld, lk);
        offer(req, rx, ld, lk, 1'b0, '0);
      end
    end

    in_valid = 1'b0;
    while (rsp_expect.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("covered %0d requests, %0d results, %0d frames, %0d retry aborts",
             n_items, n_rsp, n_frames_done, n_retry_abort);
    $display("both packet sizes, empty and maximum file lengths, all cancel paths");
    if (errors == 0 && rsp_expect.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
